FILE: sv/atr_pkg.sv
package atr_pkg;

  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned POS_W           = 6;
  localparam int unsigned RANK_W          = 8;
  localparam int unsigned MAX_SAMPLES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Classified request as it travels from front to back.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      miss;
    logic                      store;    // goes into a cell
    logic                      close;    // last request of the set
    logic                      dropped;  // set lost a sample (valid with close)
  } entry_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } back_state_e;

endpackage

FILE: sv/atr_front.sv
module atr_front #(
  parameter int unsigned MAX_SAMPLES = atr_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [atr_pkg::VALUE_W-1:0]  sample_value_i,
  input  logic                                is_missing_i,
  input  logic                                end_of_set_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output atr_pkg::entry_t                     q_entry_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             drop_q, drop_d;
  logic             accept;
  logic             store;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign store      = count_q < CNT_W'(MAX_SAMPLES);

  assign q_push_o          = accept && (store || end_of_set_i);
  assign q_entry_o.value   = sample_value_i;
  assign q_entry_o.miss    = is_missing_i;
  assign q_entry_o.store   = store;
  assign q_entry_o.close   = end_of_set_i;
  assign q_entry_o.dropped = drop_q || !store;

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (accept) begin
      if (end_of_set_i) begin
        count_d = '0;
        drop_d  = 1'b0;
      end else if (store) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

endmodule

FILE: sv/atr_queue.sv
module atr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  atr_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output atr_pkg::entry_t entry_o
);

  localparam int unsigned DEPTH = atr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  atr_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = fill_q == CNT_W'(DEPTH);
  assign empty_o = fill_q == '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: sv/atr_back.sv
module atr_back #(
  parameter int unsigned MAX_SAMPLES = atr_pkg::MAX_SAMPLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  atr_pkg::entry_t              q_entry_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [atr_pkg::POS_W-1:0]    position_o,
  output logic [atr_pkg::RANK_W-1:0]   rank_doubled_o,
  output logic                         capacity_exceeded_o,
  output logic                         last_result_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned VALUE_W = atr_pkg::VALUE_W;
  localparam int unsigned POS_W  = atr_pkg::POS_W;
  localparam int unsigned RANK_W = atr_pkg::RANK_W;

  // Cell row: each cell counts samples ranked before it and valid equals.
  // Loading scores each cell against later samples; emitting scores the
  // remaining cells against the head cell as it leaves, then shifts down.
  logic signed [VALUE_W-1:0] value_q [MAX_SAMPLES];
  logic signed [VALUE_W-1:0] value_d [MAX_SAMPLES];
  logic                      miss_q  [MAX_SAMPLES];
  logic                      miss_d  [MAX_SAMPLES];
  logic [CNT_W-1:0]          less_q  [MAX_SAMPLES];
  logic [CNT_W-1:0]          less_d  [MAX_SAMPLES];
  logic [CNT_W-1:0]          eq_q    [MAX_SAMPLES];
  logic [CNT_W-1:0]          eq_d    [MAX_SAMPLES];

  atr_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic                 drop_q, drop_d;
  logic                 emit_go;
  logic                 emit_last;

  logic                 out_valid_q;
  logic [POS_W-1:0]     position_q;
  logic [RANK_W-1:0]    rank_q;
  logic                 cap_q;
  logic                 last_q;

  assign q_pop_o   = (state_q == atr_pkg::ST_LOAD) && !q_empty_i;
  assign emit_go   = (state_q == atr_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_last = (pos_q + CNT_W'(1)) == count_q;

  always_comb begin
    value_d = value_q;
    miss_d  = miss_q;
    less_d  = less_q;
    eq_d    = eq_q;
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    drop_d  = drop_q;
    unique case (state_q)
      atr_pkg::ST_LOAD: begin
        if (q_pop_o) begin
          if (q_entry_i.store) begin
            for (int i = 0; i < MAX_SAMPLES; i++) begin
              if (CNT_W'(i) < count_q) begin
                if (!q_entry_i.miss &&
                    (miss_q[i] || (value_q[i] > q_entry_i.value))) begin
                  less_d[i] = less_q[i] + CNT_W'(1);
                end
                if (!q_entry_i.miss && !miss_q[i] && (value_q[i] == q_entry_i.value)) begin
                  eq_d[i] = eq_q[i] + CNT_W'(1);
                end
              end else if (CNT_W'(i) == count_q) begin
                value_d[i] = q_entry_i.value;
                miss_d[i]  = q_entry_i.miss;
                less_d[i]  = '0;
                eq_d[i]    = CNT_W'(1);
              end
            end
            count_d = count_q + CNT_W'(1);
          end
          if (q_entry_i.close) begin
            state_d = atr_pkg::ST_EMIT;
            drop_d  = q_entry_i.dropped;
            pos_d   = '0;
          end
        end
      end
      atr_pkg::ST_EMIT: begin
        if (emit_go) begin
          for (int i = 0; i < MAX_SAMPLES - 1; i++) begin
            value_d[i] = value_q[i+1];
            miss_d[i]  = miss_q[i+1];
            less_d[i]  = less_q[i+1];
            eq_d[i]    = eq_q[i+1];
            if (miss_q[i+1] || (!miss_q[0] && (value_q[0] < value_q[i+1]))) begin
              less_d[i] = less_q[i+1] + CNT_W'(1);
            end
            if (!miss_q[i+1] && !miss_q[0] && (value_q[0] == value_q[i+1])) begin
              eq_d[i] = eq_q[i+1] + CNT_W'(1);
            end
          end
          if (emit_last) begin
            state_d = atr_pkg::ST_LOAD;
            count_d = '0;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = atr_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atr_pkg::ST_LOAD;
      count_q     <= '0;
      pos_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      drop_q  <= drop_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    miss_q  <= miss_d;
    less_q  <= less_d;
    eq_q    <= eq_d;
    if (emit_go) begin
      position_q <= POS_W'(pos_q);
      rank_q     <= RANK_W'({less_q[0], 1'b0}) + RANK_W'(eq_q[0]) + RANK_W'(1);
      cap_q      <= drop_q;
      last_q     <= emit_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign position_o          = position_q;
  assign rank_doubled_o      = rank_q;
  assign capacity_exceeded_o = cap_q;
  assign last_result_o       = last_q;

endmodule

FILE: sv/average_tie_ranker_core.sv
// Fractional ranker with average ties.
// Input channel (in_valid_i/in_ready_o): one request per sample, with a
// missing mark; end_of_set_i on the last request closes the set.
// Output channel (out_valid_o/out_ready_i): one result per stored sample,
// in arrival order, carrying 2*less + equal + 1, the capacity flag of the
// set and last_result_o on the final one.
// Throughput: one sample per cycle while loading. Closing a set emits its
// results from the cell row, one per cycle while out_ready_i is high;
// loading of the next set waits for that, apart from a two-entry queue.
// The close passes the queue, the back state and the output register.
// Samples past MAX_SAMPLES are dropped and flagged on every result.
// Reset: set counters, the back state and the output valid clear; the
// cell contents are not cleared and need not be.
// Receiver stall: the output register holds; the cell row pauses, the
// queue fills and in_ready_o falls.
module average_tie_ranker_core #(
  parameter int unsigned MAX_SAMPLES = atr_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [atr_pkg::VALUE_W-1:0]  sample_value_i,
  input  logic                                is_missing_i,
  input  logic                                end_of_set_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [atr_pkg::POS_W-1:0]           position_o,
  output logic [atr_pkg::RANK_W-1:0]          rank_doubled_o,
  output logic                                capacity_exceeded_o,
  output logic                                last_result_o
);

  // Front -> queue -> back.
  atr_pkg::entry_t push_entry;
  atr_pkg::entry_t pop_entry;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;

  // Front: keeps its own per-set count so it can mark each request as
  // stored or dropped, and tags the closing request with the drop flag.
  atr_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_value_i(sample_value_i),
    .is_missing_i  (is_missing_i),
    .end_of_set_i  (end_of_set_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  // Short queue: lets the front keep taking requests while the back emits.
  atr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .entry_o(pop_entry)
  );

  // Back: cell row that scores each new sample against all stored ones,
  // then shifts the set out through the output register.
  atr_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_entry_i          (pop_entry),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .position_o         (position_o),
    .rank_doubled_o     (rank_doubled_o),
    .capacity_exceeded_o(capacity_exceeded_o),
    .last_result_o      (last_result_o)
  );

endmodule

FILE: sv/atr_checker.sv
module atr_checker #(
  parameter int unsigned MAX_SAMPLES = atr_pkg::MAX_SAMPLES_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [atr_pkg::POS_W-1:0]   position_i,
  input logic [atr_pkg::RANK_W-1:0]  rank_doubled_i,
  input logic                        last_result_i
);

  // Stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(position_i) &&
                                    $stable(rank_doubled_i))
    else $error("stalled result changed");

  // Doubled rank stays within 2 .. 2*MAX_SAMPLES.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (rank_doubled_i >= 2) && (32'(rank_doubled_i) <= 2 * MAX_SAMPLES))
    else $error("rank out of range");

  // Position never reaches capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(position_i) < MAX_SAMPLES)
    else $error("position out of range");

  // Highest possible position must close the set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (32'(position_i) == MAX_SAMPLES - 1) |-> last_result_i)
    else $error("full set not closed");

endmodule

bind average_tie_ranker_core atr_checker #(
  .MAX_SAMPLES(MAX_SAMPLES)
) u_atr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .position_i    (position_o),
  .rank_doubled_i(rank_doubled_o),
  .last_result_i (last_result_o)
);

FILE: verif/tb_average_tie_ranker_core.sv
module tb_average_tie_ranker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY    = atr_pkg::MAX_SAMPLES_DEF;
  localparam int unsigned RANDOM_REQS = 210;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_WAIT  = 20;

  // One ranked sample as it leaves the block.
  typedef struct packed {
    logic [atr_pkg::POS_W-1:0]  position;
    logic [atr_pkg::RANK_W-1:0] rank_doubled;
    logic                       capacity_exceeded;
    logic                       last_result;
  } rank_result_t;

  // Keeps a shadow of the cell row, updated as each request is accepted,
  // and the queue of rankings that a closed set still owes.
  class rank_scoreboard;
    logic signed [atr_pkg::VALUE_W-1:0] held_value [CAPACITY];
    bit                                 held_missing [CAPACITY];
    int unsigned                        less_cnt [CAPACITY];
    int unsigned                        equal_cnt [CAPACITY];
    int unsigned                        held_count;
    bit                                 dropped;
    rank_result_t                       owed_ranks [$];
    int unsigned                        errors;

    function new();
      held_count = 0;
      dropped    = 0;
      errors     = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function int unsigned pending();
      return owed_ranks.size();
    endfunction

    // Counts are adjusted against every held sample, so each rank is final
    // the moment the set closes. Missing samples sort last, in arrival order.
    function void note_sample(logic signed [atr_pkg::VALUE_W-1:0] value, bit miss, bit close);
      int unsigned  n;
      rank_result_t res;
      if (held_count < CAPACITY) begin
        n = held_count;
        held_value[n]   = value;
        held_missing[n] = miss;
        less_cnt[n]     = 0;
        equal_cnt[n]    = 1;
        for (int unsigned i = 0; i < n; i++) begin
          if (miss) begin
            less_cnt[n]++;
          end else if (held_missing[i]) begin
            less_cnt[i]++;
          end else if (held_value[i] == value) begin
            equal_cnt[i]++;
            equal_cnt[n]++;
          end else if (held_value[i] < value) begin
            less_cnt[n]++;
          end else begin
            less_cnt[i]++;
          end
        end
        held_count = n + 1;
      end else begin
        dropped = 1;
      end
      if (close) begin
        for (int unsigned k = 0; k < held_count; k++) begin
          res.position          = k[atr_pkg::POS_W-1:0];
          res.rank_doubled      = 8'(2 * less_cnt[k] + equal_cnt[k] + 1);
          res.capacity_exceeded = dropped;
          res.last_result       = (k + 1 == held_count);
          owed_ranks.push_back(res);
        end
        held_count = 0;
        dropped    = 0;
      end
    endfunction

    task check_result(rank_result_t got);
      rank_result_t want;
      if (owed_ranks.size() == 0) begin
        report_mismatch($sformatf("unexpected result pos %0d rank %0d",
                                  got.position, got.rank_doubled));
      end else begin
        want = owed_ranks.pop_front();
        if (got.position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
        if (got.rank_doubled !== want.rank_doubled)
          report_mismatch($sformatf("pos %0d rank %0d, want %0d", want.position,
                                    got.rank_doubled, want.rank_doubled));
        if (got.capacity_exceeded !== want.capacity_exceeded)
          report_mismatch($sformatf("pos %0d capacity flag %0b, want %0b", want.position,
                                    got.capacity_exceeded, want.capacity_exceeded));
        if (got.last_result !== want.last_result)
          report_mismatch($sformatf("pos %0d last flag %0b, want %0b", want.position,
                                    got.last_result, want.last_result));
      end
    endtask
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [atr_pkg::VALUE_W-1:0] sample_value_i;
  logic                               is_missing_i;
  logic                               end_of_set_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [atr_pkg::POS_W-1:0]          position_o;
  logic [atr_pkg::RANK_W-1:0]         rank_doubled_o;
  logic                               capacity_exceeded_o;
  logic                               last_result_o;

  rank_scoreboard board = new();

  // Idling percentages for the current phase; sender and receiver separately.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  average_tie_ranker_core #(
    .MAX_SAMPLES(CAPACITY)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_value_i     (sample_value_i),
    .is_missing_i       (is_missing_i),
    .end_of_set_i       (end_of_set_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .position_o         (position_o),
    .rank_doubled_o     (rank_doubled_o),
    .capacity_exceeded_o(capacity_exceeded_o),
    .last_result_o      (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a generous bound on the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: values seen here are the ones from before the edge, so a
  // result counts when valid and ready were both high going into it.
  // Ready is then redrawn for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result({position_o, rank_doubled_o, capacity_exceeded_o, last_result_o});
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one request; valid is left high afterwards so back-to-back
  // requests carry no bubble unless the idle draw asks for one.
  task automatic send_sample(logic signed [atr_pkg::VALUE_W-1:0] value, bit miss, bit close);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    is_missing_i   <= miss;
    end_of_set_i   <= close;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_sample(value, miss, close);
  endtask

  // Biased towards ties and the ends of the signed range.
  function automatic logic [atr_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return 32'($urandom_range(4)) - 32'd2;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0001;
          default: return 32'h7fff_fffe;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned set_len;
    int unsigned phase;
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];

    idle_tab  = '{0, 49, 0, 31};
    stall_tab = '{0, 0, 49, 31};

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    sample_value_i <= '0;
    is_missing_i   <= 1'b0;
    end_of_set_i   <= 1'b0;
    out_ready_i    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets, no idling.
    // Extremes, sign-bit neighbours, ties and missing samples mixed in.
    send_sample(32'sh8000_0000, 1'b0, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0, 1'b0);
    send_sample(32'sh0000_0000, 1'b0, 1'b0);
    send_sample(-32'sd1,        1'b0, 1'b0);
    send_sample(32'sh0000_0000, 1'b0, 1'b0);
    send_sample(32'sd5,         1'b1, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 1'b1, 1'b1);
    // Single valid sample, then a single missing one.
    send_sample(32'sd1,  1'b0, 1'b1);
    send_sample(-32'sd1, 1'b1, 1'b1);
    // All tied.
    send_sample(32'sd7, 1'b0, 1'b0);
    send_sample(32'sd7, 1'b0, 1'b0);
    send_sample(32'sd7, 1'b0, 1'b1);
    // Missing ahead of valid: they must still rank last.
    send_sample(32'sh7fff_ffff, 1'b1, 1'b0);
    send_sample(32'sd0,         1'b1, 1'b0);
    send_sample(32'sh8000_0000, 1'b0, 1'b1);

    // Random sets. The first overruns capacity so the drop flag and a
    // close on a discarded request are always seen; later ones are mostly
    // short, with the odd long set near or past the limit.
    sent = 0;
    set_len = CAPACITY + $urandom_range(1, 3);
    while (sent < RANDOM_REQS) begin
      phase = (sent * 4) / RANDOM_REQS;
      send_idle_pct  = idle_tab[phase];
      recv_stall_pct = stall_tab[phase];
      for (int unsigned j = 0; j < set_len; j++)
        send_sample(pick_value(), ($urandom_range(4) == 0), (j + 1 == set_len));
      sent += set_len;
      set_len = ($urandom_range(11) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 4)
                                          : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
